FILE: hw/rtl/memory_board_region_decoder_unit_assert.svh
// Assertion macros shared by the memory board decoder RTL.
`ifndef MEMORY_BOARD_REGION_DECODER_UNIT_ASSERT_SVH
`define MEMORY_BOARD_REGION_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define MBRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("memory board decoder: same-cycle check failed");

// Next-cycle implication, masked while reset is asserted.
`define MBRD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("memory board decoder: next-cycle check failed");

`endif

FILE: hw/rtl/mbrd_pkg.sv
package mbrd_pkg;

    localparam int unsigned ADDR_W   = 24;
    localparam int unsigned KW_SHIFT = 10;
    localparam int unsigned PAGE_W   = ADDR_W - KW_SHIFT;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned MAX_ROMS = 2;

    localparam int unsigned RAM_DEPTH_DEF = 65536;
    localparam int unsigned ROM_DEPTH_DEF = 16384;
    localparam int unsigned ROM_COUNT_DEF = 2;

    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [6:0] RAM_SIZE_KW_RST = 7'd64;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_PRELOAD = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_NO_MEM     = 2'd1,
        ST_RO_IGNORED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RGN_RAM      = 2'd0,
        RGN_ROM_LOW  = 2'd1,
        RGN_ROM_HIGH = 2'd2,
        RGN_NONE     = 2'd3
    } t_region;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RAM_SIZE      = 3'd0,
        CFG_ROM_LOW_BASE  = 3'd1,
        CFG_ROM_LOW_SIZE  = 3'd2,
        CFG_ROM_HIGH_BASE = 3'd3,
        CFG_ROM_HIGH_SIZE = 3'd4,
        CFG_ROM_WRITABLE  = 3'd5,
        CFG_FILL_VALUE    = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [6:0]        ram_size_kw;
        logic [PAGE_W-1:0] rom_low_base_kw;
        logic [4:0]        rom_low_size_kw;
        logic [PAGE_W-1:0] rom_high_base_kw;
        logic [4:0]        rom_high_size_kw;
        logic              rom_writable;
        logic [WORD_W-1:0] ram_fill_value;
    } t_cfg;

    typedef struct packed {
        logic    hit;
        logic    is_rom;
        t_region region;
    } t_decode;

endpackage

FILE: hw/rtl/mbrd_ram.sv
module mbrd_ram #(
    parameter int unsigned WIDTH = mbrd_pkg::WORD_W,
    parameter int unsigned DEPTH = mbrd_pkg::RAM_DEPTH_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/mbrd_decode.sv
module mbrd_decode #(
    parameter int unsigned RAM_DEPTH = mbrd_pkg::RAM_DEPTH_DEF,
    parameter int unsigned ROM_DEPTH = mbrd_pkg::ROM_DEPTH_DEF,
    parameter int unsigned ROM_COUNT = mbrd_pkg::ROM_COUNT_DEF,
    localparam int unsigned RAM_AW   = $clog2(RAM_DEPTH),
    localparam int unsigned ROM_AW   = $clog2(ROM_COUNT * ROM_DEPTH)
) (
    input  mbrd_pkg::t_cfg                   i_cfg,
    input  logic [mbrd_pkg::ADDR_W-1:0]      i_addr,
    output mbrd_pkg::t_decode                o_dec,
    output logic [RAM_AW-1:0]                o_ram_addr,
    output logic [ROM_AW-1:0]                o_rom_addr
);

    localparam int unsigned AW = mbrd_pkg::ADDR_W;
    localparam int unsigned PW = mbrd_pkg::PAGE_W;
    localparam int unsigned NR = mbrd_pkg::MAX_ROMS;

    logic [PW-1:0] page;
    logic [PW-1:0] rom_base  [NR];
    logic [4:0]    rom_size  [NR];
    logic [PW-1:0] rom_dpage [NR];
    logic [AW-1:0] rom_off   [NR];
    logic [NR-1:0] rom_hit;
    logic          ram_hit;

    assign page        = i_addr[AW-1:mbrd_pkg::KW_SHIFT];
    assign rom_base[0] = i_cfg.rom_low_base_kw;
    assign rom_base[1] = i_cfg.rom_high_base_kw;
    assign rom_size[0] = i_cfg.rom_low_size_kw;
    assign rom_size[1] = i_cfg.rom_high_size_kw;

    // Each ROM window: page at or above base, offset under both size and depth.
    always_comb begin
        for (int r = 0; r < NR; r++) begin
            rom_dpage[r] = page - rom_base[r];
            rom_off[r]   = {rom_dpage[r], i_addr[mbrd_pkg::KW_SHIFT-1:0]};
            rom_hit[r]   = (r < ROM_COUNT) && (rom_size[r] != 5'd0)
                        && (page >= rom_base[r])
                        && (rom_dpage[r] < PW'(rom_size[r]))
                        && (rom_off[r] < AW'(ROM_DEPTH));
        end
    end

    assign ram_hit = (page < PW'(i_cfg.ram_size_kw))
                  && ({1'b0, i_addr} < (AW + 1)'(RAM_DEPTH));

    always_comb begin
        o_dec.hit    = 1'b1;
        o_dec.is_rom = 1'b1;
        o_dec.region = mbrd_pkg::RGN_NONE;
        o_rom_addr   = ROM_AW'(rom_off[0]);
        if (rom_hit[1]) begin
            o_dec.region = mbrd_pkg::RGN_ROM_HIGH;
            o_rom_addr   = ROM_AW'(ROM_DEPTH) + ROM_AW'(rom_off[1]);
        end else if (rom_hit[0]) begin
            o_dec.region = mbrd_pkg::RGN_ROM_LOW;
        end else if (ram_hit) begin
            o_dec.is_rom = 1'b0;
            o_dec.region = mbrd_pkg::RGN_RAM;
        end else begin
            o_dec.hit    = 1'b0;
            o_dec.is_rom = 1'b0;
        end
    end

    assign o_ram_addr = i_addr[RAM_AW-1:0];

endmodule

FILE: hw/rtl/memory_board_region_decoder_unit.sv
// Results appear in the cycle after input accept (registered RAM read).
// Throughput: one transaction per cycle while results are taken and RAM is
// not being cleared; set by single-port RAM and ROM, one access per cycle each.
// Reset (i_rst_n low at a clock edge) restores register defaults, then a
// clearing pass fills all RAM_DEPTH words (65536 by default) with the fill
// word; the same pass reruns after each ram_fill_value write. ROM is not cleared.
`include "memory_board_region_decoder_unit_assert.svh"

module memory_board_region_decoder_unit #(
    parameter int unsigned RAM_DEPTH = mbrd_pkg::RAM_DEPTH_DEF,
    parameter int unsigned ROM_DEPTH = mbrd_pkg::ROM_DEPTH_DEF,
    parameter int unsigned ROM_COUNT = mbrd_pkg::ROM_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Stream in, tdata from bit 0: opcode[1:0], word_address[25:2],
    // write_word[41:26], zero pad[47:42]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mbrd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Stream out, tdata from bit 0: read_word[15:0], status[17:16],
    // hit_region[19:18], zero pad[23:20]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mbrd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Register write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mbrd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mbrd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);
    localparam int unsigned ROM_WORDS = ROM_COUNT * ROM_DEPTH;
    localparam int unsigned ROM_AW    = $clog2(ROM_WORDS);
    localparam int unsigned WW        = mbrd_pkg::WORD_W;
    localparam int unsigned AW        = mbrd_pkg::ADDR_W;
    localparam int unsigned PW        = mbrd_pkg::PAGE_W;
    localparam int unsigned OUT_PAD   = mbrd_pkg::OUT_TDATA_W - WW - 4;
    localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(RAM_DEPTH - 1);

    // ------------------------------------------------------------------
    // Register file. Writes are always taken; unknown indexes are dropped.
    // ------------------------------------------------------------------
    mbrd_pkg::t_cfg         r_cfg;
    mbrd_pkg::t_cfg_index   cfg_idx;
    logic                   cfg_fire;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;
    assign cfg_idx     = mbrd_pkg::t_cfg_index'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ram_size_kw      <= mbrd_pkg::RAM_SIZE_KW_RST;
            r_cfg.rom_low_base_kw  <= '0;
            r_cfg.rom_low_size_kw  <= '0;
            r_cfg.rom_high_base_kw <= '0;
            r_cfg.rom_high_size_kw <= '0;
            r_cfg.rom_writable     <= 1'b0;
            r_cfg.ram_fill_value   <= '0;
        end else if (cfg_fire) begin
            case (cfg_idx)
                mbrd_pkg::CFG_RAM_SIZE:      r_cfg.ram_size_kw      <= i_cfg_wdata[6:0];
                mbrd_pkg::CFG_ROM_LOW_BASE:  r_cfg.rom_low_base_kw  <= i_cfg_wdata[PW-1:0];
                mbrd_pkg::CFG_ROM_LOW_SIZE:  r_cfg.rom_low_size_kw  <= i_cfg_wdata[4:0];
                mbrd_pkg::CFG_ROM_HIGH_BASE: r_cfg.rom_high_base_kw <= i_cfg_wdata[PW-1:0];
                mbrd_pkg::CFG_ROM_HIGH_SIZE: r_cfg.rom_high_size_kw <= i_cfg_wdata[4:0];
                mbrd_pkg::CFG_ROM_WRITABLE:  r_cfg.rom_writable     <= i_cfg_wdata[0];
                mbrd_pkg::CFG_FILL_VALUE:    r_cfg.ram_fill_value   <= i_cfg_wdata[WW-1:0];
                default: begin
                    r_cfg.rom_writable <= r_cfg.rom_writable;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // RAM clearing pass: one word per cycle, owns the RAM port while busy.
    // A fill-word write restarts it from address zero with the new word.
    // ------------------------------------------------------------------
    logic              r_clr_busy;
    logic [RAM_AW-1:0] r_clr_addr;
    logic              fill_write;

    assign fill_write = cfg_fire && (cfg_idx == mbrd_pkg::CFG_FILL_VALUE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (fill_write) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + RAM_AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Accept and decode. A result in the output register that is not being
    // taken blocks the next access, since the arrays' read registers carry
    // its data word.
    // ------------------------------------------------------------------
    mbrd_pkg::t_opcode   in_op;
    logic [AW-1:0]       in_addr;
    logic [WW-1:0]       in_wdata;
    logic                s_fire;
    logic                r_out_valid;
    mbrd_pkg::t_decode   dec;
    logic [RAM_AW-1:0]   dec_ram_addr;
    logic [ROM_AW-1:0]   dec_rom_addr;
    logic                acc_rd;
    logic                acc_wr;
    mbrd_pkg::t_status   acc_status;

    assign in_op    = mbrd_pkg::t_opcode'(s_axis_tdata[1:0]);
    assign in_addr  = s_axis_tdata[AW+1:2];
    assign in_wdata = s_axis_tdata[AW+WW+1:AW+2];

    assign m_axis_tvalid = r_out_valid;
    assign s_axis_tready = !r_clr_busy && (!r_out_valid || m_axis_tready);
    assign s_fire        = s_axis_tvalid & s_axis_tready;

    mbrd_decode #(
        .RAM_DEPTH (RAM_DEPTH),
        .ROM_DEPTH (ROM_DEPTH),
        .ROM_COUNT (ROM_COUNT)
    ) u_decode (
        .i_cfg      (r_cfg),
        .i_addr     (in_addr),
        .o_dec      (dec),
        .o_ram_addr (dec_ram_addr),
        .o_rom_addr (dec_rom_addr)
    );

    // Protection check: plain writes to ROM go through only in writable mode.
    always_comb begin
        acc_rd     = 1'b0;
        acc_wr     = 1'b0;
        acc_status = mbrd_pkg::ST_NO_MEM;
        if (dec.hit) begin
            acc_status = mbrd_pkg::ST_DONE;
            case (in_op)
                mbrd_pkg::OP_READ: begin
                    acc_rd = 1'b1;
                end
                mbrd_pkg::OP_WRITE: begin
                    if (!dec.is_rom || r_cfg.rom_writable) begin
                        acc_wr = 1'b1;
                    end else begin
                        acc_status = mbrd_pkg::ST_RO_IGNORED;
                    end
                end
                mbrd_pkg::OP_PRELOAD: begin
                    acc_wr = 1'b1;
                end
                default: begin
                    acc_rd = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Storage. A write commits at the accept edge, so any later read,
    // issued at a later edge, sees it without forwarding.
    // ------------------------------------------------------------------
    logic              ram_en;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [WW-1:0]     ram_wdata;
    logic [WW-1:0]     ram_q;
    logic              rom_en;
    logic              rom_we;
    logic [WW-1:0]     rom_q;

    assign ram_en    = r_clr_busy || (s_fire && !dec.is_rom && (acc_rd || acc_wr));
    assign ram_we    = r_clr_busy || (s_fire && !dec.is_rom && acc_wr);
    assign ram_addr  = r_clr_busy ? r_clr_addr : dec_ram_addr;
    assign ram_wdata = r_clr_busy ? r_cfg.ram_fill_value : in_wdata;

    assign rom_en = s_fire && dec.is_rom && (acc_rd || acc_wr);
    assign rom_we = s_fire && dec.is_rom && acc_wr;

    mbrd_ram #(
        .WIDTH (WW),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    mbrd_ram #(
        .WIDTH (WW),
        .DEPTH (ROM_WORDS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_en    (rom_en),
        .i_we    (rom_we),
        .i_addr  (dec_rom_addr),
        .i_wdata (in_wdata),
        .o_rdata (rom_q)
    );

    // ------------------------------------------------------------------
    // Output register: status and region travel beside the array read.
    // ------------------------------------------------------------------
    mbrd_pkg::t_status  r_out_status;
    mbrd_pkg::t_region  r_out_region;
    logic               r_out_rd;
    logic               r_out_rom;
    logic [WW-1:0]      out_word;
    logic               out_unmapped;
    logic               out_no_mem;
    logic               out_protected;
    logic               out_on_rom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_status <= acc_status;
            r_out_region <= dec.region;
            r_out_rd     <= acc_rd;
            r_out_rom    <= dec.is_rom;
        end
    end

    // Zero unless the access was a successful read.
    assign out_word     = r_out_rd ? (r_out_rom ? rom_q : ram_q) : '0;
    assign m_axis_tdata = {OUT_PAD'(0), r_out_region, r_out_status, out_word};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    assign out_unmapped  = (r_out_region == mbrd_pkg::RGN_NONE);
    assign out_no_mem    = (r_out_status == mbrd_pkg::ST_NO_MEM);
    assign out_protected = (r_out_status == mbrd_pkg::ST_RO_IGNORED);
    assign out_on_rom    = r_out_region inside {mbrd_pkg::RGN_ROM_LOW, mbrd_pkg::RGN_ROM_HIGH};

    `MBRD_ASSERT_NXT(a_fill_restarts_clear, i_clk, i_rst_n, fill_write, r_clr_busy)
    `MBRD_ASSERT_IMP(a_no_accept_while_clear, i_clk, i_rst_n, r_clr_busy, !s_axis_tready)
    `MBRD_ASSERT_IMP(a_unmapped_matches_status, i_clk, i_rst_n, r_out_valid, out_unmapped == out_no_mem)
    `MBRD_ASSERT_IMP(a_protect_only_on_rom, i_clk, i_rst_n, r_out_valid && out_protected, out_on_rom)
    `MBRD_ASSERT_NXT(a_stalled_word_holds, i_clk, i_rst_n, r_out_valid && !m_axis_tready, $stable(out_word))

endmodule
